// ===== design/sha1h_pkg.sv =====
package sha1h_pkg;

   localparam int WORD_W     = 32;
   localparam int NUM_CHAIN  = 5;
   localparam int NUM_SCHED  = 16;
   localparam int WIN_W      = NUM_SCHED * WORD_W;
   localparam int ROUND_W    = 7;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 64;
   localparam int OUT_IDX_W  = 3;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [NUM_CHAIN-1:0] chain_type;

   localparam chain_type CHAIN_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                       32'hEFCDAB89, 32'h67452301};

   localparam logic [INDEX_W-1:0]   LAST_INDEX = 6'd63;
   localparam logic [INDEX_W-1:0]   LEN_INDEX  = 6'd56;
   localparam logic [ROUND_W-1:0]   LAST_ROUND = 7'd79;
   localparam logic [OUT_IDX_W-1:0] LAST_WORD  = 3'd4;
   localparam logic [7:0]           PAD_BYTE   = 8'h80;
   localparam logic [COUNT_W-1:0]   BYTE_BITS  = 64'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_ONE,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_MSG,
      PH_ONE,
      PH_ZERO,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic       push;
      logic       step;
      logic [7:0] data;
   } sched_ctrl_type;

   typedef struct packed {
      logic               load;
      logic               step;
      logic [ROUND_W-1:0] round_idx;
   } round_ctrl_type;

   function automatic word_type round_k(input logic [ROUND_W-1:0] idx);
      word_type k;
      if (idx < 7'd20) begin
         k = 32'h5A827999;
      end else if (idx < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (idx < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

endpackage

// ===== design/sha1h_sched.sv =====
module sha1h_sched (
   input  logic                     clock,
   input  sha1h_pkg::sched_ctrl_type ctrl,
   output sha1h_pkg::word_type       w_cur
);

   logic [sha1h_pkg::WIN_W-1:0] win_ff;
   logic [sha1h_pkg::WIN_W-1:0] win_in;
   sha1h_pkg::word_type         w_next;

   // word i of the window sits at win_ff[WIN_W-1-32*i -: 32]
   always_comb begin
      w_next = win_ff[sha1h_pkg::WIN_W-1 -: 32] ^ win_ff[447:416] ^
               win_ff[255:224] ^ win_ff[95:64];
      w_next = {w_next[30:0], w_next[31]};
   end

   always_comb begin
      win_in = win_ff;
      if (ctrl.push) begin
         win_in = {win_ff[sha1h_pkg::WIN_W-9:0], ctrl.data};
      end else if (ctrl.step) begin
         win_in = {win_ff[sha1h_pkg::WIN_W-33:0], w_next};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign w_cur = win_ff[sha1h_pkg::WIN_W-1 -: 32];

endmodule

// ===== design/sha1h_round.sv =====
module sha1h_round (
   input  logic                     clock,
   input  sha1h_pkg::round_ctrl_type ctrl,
   input  sha1h_pkg::chain_type      chain,
   input  sha1h_pkg::word_type       w,
   output sha1h_pkg::chain_type      work
);

   sha1h_pkg::chain_type work_ff;
   sha1h_pkg::chain_type work_in;
   sha1h_pkg::word_type  a, b, c, d, e, f, t;

   always_comb begin
      a = work_ff[0];
      b = work_ff[1];
      c = work_ff[2];
      d = work_ff[3];
      e = work_ff[4];
      if (ctrl.round_idx < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (ctrl.round_idx >= 7'd40 && ctrl.round_idx < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      t = {a[26:0], a[31:27]} + f + e + sha1h_pkg::round_k(ctrl.round_idx) + w;
   end

   always_comb begin
      work_in = work_ff;
      if (ctrl.load) begin
         work_in = chain;
      end else if (ctrl.step) begin
         work_in[4] = d;
         work_in[3] = c;
         work_in[2] = {b[1:0], b[31:2]};
         work_in[1] = a;
         work_in[0] = t;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign work = work_ff;

endmodule

// ===== design/sha1_hash_core.sv =====
// SHA-1 over a byte stream, one byte per req word. Every 64th byte starts the
// 80-round compression on the single shared round unit (one round per cycle),
// followed by a step that folds the result into the chaining words. req_stall
// stays high while a block is compressed. A word with req_is_last set (with or
// without a byte) starts padding, fed through the same byte path at one byte per
// cycle outside compression: the 0x80 marker, zeros up to byte 56 and the eight
// length bytes, with an extra compression when the marker lands past byte 55.
// The five digest words H0..H4 then follow on rsp, one per accepted rsp word,
// and the core is ready for the next message once the fifth is taken.
module sha1_hash_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_word_last
);

   sha1h_pkg::state_type state_ff, state_in;
   sha1h_pkg::phase_type phase_ff, phase_in;

   logic [sha1h_pkg::INDEX_W-1:0]   index_ff, index_in;
   logic [sha1h_pkg::COUNT_W-1:0]   bit_count_ff, bit_count_in;
   logic [sha1h_pkg::ROUND_W-1:0]   round_ff, round_in;
   logic [sha1h_pkg::OUT_IDX_W-1:0] out_idx_ff, out_idx_in;
   sha1h_pkg::chain_type            chain_ff, chain_in;
   sha1h_pkg::chain_type            work;
   sha1h_pkg::word_type             w_cur;

   sha1h_pkg::sched_ctrl_type sched_ctrl;
   sha1h_pkg::round_ctrl_type round_ctrl;

   logic byte_wr;
   logic msg_byte;
   logic rsp_take;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha1h_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte && index_ff == sha1h_pkg::LAST_INDEX) begin
                  state_in = sha1h_pkg::ST_ROUND;
               end else if (req_is_last) begin
                  state_in = sha1h_pkg::ST_PAD_ONE;
               end
            end
         end
         sha1h_pkg::ST_PAD_ONE: begin
            state_in = (index_ff == sha1h_pkg::LAST_INDEX) ? sha1h_pkg::ST_ROUND
                                                           : sha1h_pkg::ST_PAD_ZERO;
         end
         sha1h_pkg::ST_PAD_ZERO: begin
            if (index_ff == sha1h_pkg::LEN_INDEX) begin
               state_in = sha1h_pkg::ST_PAD_LEN;
            end else if (index_ff == sha1h_pkg::LAST_INDEX) begin
               state_in = sha1h_pkg::ST_ROUND;
            end
         end
         sha1h_pkg::ST_PAD_LEN: begin
            if (index_ff == sha1h_pkg::LAST_INDEX) begin
               state_in = sha1h_pkg::ST_ROUND;
            end
         end
         sha1h_pkg::ST_ROUND: begin
            if (round_ff == sha1h_pkg::LAST_ROUND) begin
               state_in = sha1h_pkg::ST_ADD;
            end
         end
         sha1h_pkg::ST_ADD: begin
            unique case (phase_ff)
               sha1h_pkg::PH_MSG:  state_in = sha1h_pkg::ST_IDLE;
               sha1h_pkg::PH_ONE:  state_in = sha1h_pkg::ST_PAD_ONE;
               sha1h_pkg::PH_ZERO: state_in = sha1h_pkg::ST_PAD_ZERO;
               sha1h_pkg::PH_DONE: state_in = sha1h_pkg::ST_OUT;
               default:            state_in = sha1h_pkg::ST_IDLE;
            endcase
         end
         sha1h_pkg::ST_OUT: begin
            if (!rsp_stall && out_idx_ff == sha1h_pkg::LAST_WORD) begin
               state_in = sha1h_pkg::ST_IDLE;
            end
         end
         default: state_in = sha1h_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      byte_wr         = 1'b0;
      msg_byte        = 1'b0;
      sched_ctrl.data = 8'h00;
      phase_in        = phase_ff;
      unique case (state_ff)
         sha1h_pkg::ST_IDLE: begin
            msg_byte        = req_valid && req_has_byte;
            byte_wr         = msg_byte;
            sched_ctrl.data = req_data_byte;
            if (req_valid) begin
               phase_in = req_is_last ? sha1h_pkg::PH_ONE : sha1h_pkg::PH_MSG;
            end
         end
         sha1h_pkg::ST_PAD_ONE: begin
            byte_wr         = 1'b1;
            sched_ctrl.data = sha1h_pkg::PAD_BYTE;
            phase_in        = sha1h_pkg::PH_ZERO;
         end
         sha1h_pkg::ST_PAD_ZERO: begin
            byte_wr = (index_ff != sha1h_pkg::LEN_INDEX);
         end
         sha1h_pkg::ST_PAD_LEN: begin
            byte_wr         = 1'b1;
            sched_ctrl.data = bit_count_ff[sha1h_pkg::COUNT_W-1 -: 8];
            phase_in        = sha1h_pkg::PH_DONE;
         end
         default: begin
         end
      endcase

      rsp_take = (state_ff == sha1h_pkg::ST_OUT) && !rsp_stall;

      sched_ctrl.push = byte_wr;
      sched_ctrl.step = (state_ff == sha1h_pkg::ST_ROUND);

      round_ctrl.load      = byte_wr && index_ff == sha1h_pkg::LAST_INDEX;
      round_ctrl.step      = (state_ff == sha1h_pkg::ST_ROUND);
      round_ctrl.round_idx = round_ff;

      index_in = byte_wr ? index_ff + 6'd1 : index_ff;

      round_in = round_ff;
      if (round_ctrl.load) begin
         round_in = '0;
      end else if (round_ctrl.step) begin
         round_in = round_ff + 7'd1;
      end

      bit_count_in = bit_count_ff;
      if (msg_byte) begin
         bit_count_in = bit_count_ff + sha1h_pkg::BYTE_BITS;
      end else if (state_ff == sha1h_pkg::ST_PAD_LEN) begin
         bit_count_in = {bit_count_ff[sha1h_pkg::COUNT_W-9:0], 8'h00};
      end

      chain_in   = chain_ff;
      out_idx_in = out_idx_ff;
      if (state_ff == sha1h_pkg::ST_ADD) begin
         for (int i = 0; i < sha1h_pkg::NUM_CHAIN; i++) begin
            chain_in[i] = chain_ff[i] + work[i];
         end
      end
      if (rsp_take) begin
         if (out_idx_ff == sha1h_pkg::LAST_WORD) begin
            out_idx_in   = '0;
            chain_in     = sha1h_pkg::CHAIN_INIT;
            bit_count_in = '0;
         end else begin
            out_idx_in = out_idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha1h_pkg::ST_IDLE;
         phase_ff     <= sha1h_pkg::PH_MSG;
         index_ff     <= '0;
         bit_count_ff <= '0;
         round_ff     <= '0;
         out_idx_ff   <= '0;
         chain_ff     <= sha1h_pkg::CHAIN_INIT;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         bit_count_ff <= bit_count_in;
         round_ff     <= round_in;
         out_idx_ff   <= out_idx_in;
         chain_ff     <= chain_in;
      end
   end

   sha1h_sched u_sched (
      .clock (clock),
      .ctrl  (sched_ctrl),
      .w_cur (w_cur)
   );

   sha1h_round u_round (
      .clock (clock),
      .ctrl  (round_ctrl),
      .chain (chain_ff),
      .w     (w_cur),
      .work  (work)
   );

   assign req_stall       = (state_ff != sha1h_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == sha1h_pkg::ST_OUT);
   assign rsp_digest_word = chain_ff[out_idx_ff];
   assign rsp_word_last   = (out_idx_ff == sha1h_pkg::LAST_WORD);

endmodule

// ===== design/sha1_hash_core_chk.sv =====
module sha1_hash_core_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_has_byte,
   input logic        req_is_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic        rsp_word_last
);

   // no new req word while the digest is going out
   a_busy_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req taken while digest pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word) &&
                                 $stable(rsp_word_last))
      else $error("stalled rsp word changed");

   a_last_word_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_word_last |=> !rsp_valid && !req_stall)
      else $error("core not idle after final digest word");

   // padding always takes cycles before the digest
   a_pad_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_is_last |=> !rsp_valid)
      else $error("digest without padding");

   a_empty_word_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_has_byte && !req_is_last |=> !req_stall)
      else $error("empty word left core busy");

endmodule

bind sha1_hash_core sha1_hash_core_chk u_chk (.*);

// ===== verif/sha1_digest_checker.sv =====
module sha1_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_is_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_word,
   input  logic        rsp_word_last,
   output int          fail_count,
   output int          words_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      sha1h_pkg::word_type digest;
      logic                last;
   } digest_word_type;

   sha1h_pkg::chain_type chain_h;
   logic [7:0]           msg_block [64];
   int unsigned          fill_index;
   logic [63:0]          length_bits;
   digest_word_type      expected_digest [$];
   int                   errors = 0;

   function automatic void clear_message();
      chain_h     = sha1h_pkg::CHAIN_INIT;
      fill_index  = 0;
      length_bits = '0;
   endfunction

   function automatic void sha1_compress();
      sha1h_pkg::word_type w [16];
      sha1h_pkg::word_type a, b, c, d, e, f, k, t, x;
      int                  r, j;
      for (j = 0; j < 16; j++) begin
         w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
      end
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (r = 0; r < 80; r++) begin
         if (r >= 16) begin
            x = w[(r-3) & 15] ^ w[(r-8) & 15] ^ w[(r-14) & 15] ^ w[r & 15];
            w[r & 15] = {x[30:0], x[31]};
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   function automatic void absorb_byte(input logic [7:0] data);
      msg_block[fill_index] = data;
      fill_index++;
      if (fill_index == 64) begin
         sha1_compress();
         length_bits += 64'd512;
         fill_index = 0;
      end
   endfunction

   // pad, append the bit length, emit H0..H4 and start over
   function automatic void pad_and_finish();
      digest_word_type entry;
      int              j;
      length_bits += 64'(fill_index) << 3;
      msg_block[fill_index] = sha1h_pkg::PAD_BYTE;
      fill_index++;
      if (fill_index > sha1h_pkg::LEN_INDEX) begin
         while (fill_index < 64) begin
            msg_block[fill_index] = 8'h00;
            fill_index++;
         end
         sha1_compress();
         fill_index = 0;
      end
      while (fill_index < sha1h_pkg::LEN_INDEX) begin
         msg_block[fill_index] = 8'h00;
         fill_index++;
      end
      for (j = 0; j < 8; j++) begin
         msg_block[sha1h_pkg::LEN_INDEX + j] = length_bits[63 - 8*j -: 8];
      end
      sha1_compress();
      for (j = 0; j < sha1h_pkg::NUM_CHAIN; j++) begin
         entry.digest = chain_h[j];
         entry.last   = (j == sha1h_pkg::NUM_CHAIN - 1);
         expected_digest.push_back(entry);
      end
      clear_message();
   endfunction

   always @(posedge clock) begin
      digest_word_type want;
      if (reset) begin
         clear_message();
         expected_digest.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_has_byte) begin
               absorb_byte(req_data_byte);
            end
            if (req_is_last) begin
               pad_and_finish();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_digest.size() == 0) begin
               errors++;
               $display("%0t: unexpected rsp word: expected none, actual %h last %b",
                        $time, rsp_digest_word, rsp_word_last);
            end else begin
               want = expected_digest.pop_front();
               if (rsp_digest_word !== want.digest) begin
                  errors++;
                  $display("%0t: digest word: expected %h, actual %h",
                           $time, want.digest, rsp_digest_word);
               end
               if (rsp_word_last !== want.last) begin
                  errors++;
                  $display("%0t: word_last: expected %b, actual %b",
                           $time, want.last, rsp_word_last);
               end
            end
         end
      end
      fail_count    <= errors;
      words_pending <= expected_digest.size();
   end

endmodule

// ===== verif/sha1_hash_core_test.sv =====
module sha1_hash_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic        rsp_word_last;
   int          fail_count;
   int          words_pending;

   logic        quiet_tail = 1'b0;
   logic        req_idling = 1'b1;
   int          items_sent = 0;
   int          msg_len;
   int          stall_len;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sha1_hash_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_last   (rsp_word_last)
   );

   sha1_digest_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_last   (rsp_word_last),
      .fail_count      (fail_count),
      .words_pending   (words_pending)
   );

   task automatic pause_request(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_word(input logic [7:0] data, input logic has, input logic last);
      if (req_idling && !quiet_tail && $urandom_range(0, 4) == 0) begin
         pause_request($urandom_range(1, 9));
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_has_byte  <= has;
      req_is_last   <= last;
      do begin
         @(posedge clock);
      end while (req_stall);
      items_sent++;
   endtask

   // random bytes, stray empty words, last flag on the final byte or on its own word
   task automatic send_message(input int len);
      int i;
      logic joined;
      joined = (len > 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_word(8'($urandom_range(0, 255)), 1'b1, joined && (i == len - 1));
      end
      if (!joined) begin
         send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
   endtask

   initial begin
      @(negedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            stall_len = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (stall_len) @(negedge clock);
         end else if ($urandom_range(0, 15) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // empty message, single-byte messages 0x00 and 0xFE, ignored words, bare last
      send_word(8'hA5, 1'b0, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'h3C, 1'b0, 1'b0);
      send_word(8'h80, 1'b1, 1'b0);
      send_word(8'hFF, 1'b0, 1'b1);
      send_word(8'h55, 1'b1, 1'b0);
      send_word(8'hAA, 1'b1, 1'b1);
      send_word(8'h01, 1'b0, 1'b0);
      send_word(8'hFE, 1'b1, 1'b1);

      items_sent = 0;
      while (items_sent < 310) begin
         req_idling = ($urandom_range(0, 3) != 0);
         if (items_sent >= 250) begin
            quiet_tail = 1'b1;
         end
         case ($urandom_range(0, 7))
            0, 1, 2: msg_len = $urandom_range(0, 12);
            3, 4, 5: msg_len = $urandom_range(52, 66);
            6:       msg_len = $urandom_range(110, 130);
            default: msg_len = $urandom_range(0, 64);
         endcase
         send_message(msg_len);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (words_pending != 0) begin
         @(posedge clock);
      end
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
